[src/hbfd_pkg.sv]
// Shared constants and codes for the heartbeat failure detector.
// Used by heartbeat_failure_detector_unit; no dependencies.
`default_nettype none

package hbfd_pkg;

  // Table geometry
  localparam int NODES  = 16;
  localparam int NODE_W = 4;
  localparam int TIME_W = 32;
  localparam int THR_W  = 31;
  localparam int IVL_W  = 16;
  localparam int CFG_W  = 31;

  // Request kinds
  localparam logic [1:0] KIND_REGISTER  = 2'd0;
  localparam logic [1:0] KIND_REMOVE    = 2'd1;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd2;
  localparam logic [1:0] KIND_TICK      = 2'd3;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_INTERVAL  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(3000);
  localparam logic [IVL_W-1:0] INTERVAL_RESET  = IVL_W'(1000);

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CHECK = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[src/heartbeat_failure_detector_unit.sv]
// Heartbeat failure detector: node table controller and scan engine.
// Register, remove, heartbeat and non-scanning tick requests are handled in S_IDLE, which stays ready.
// A scanning tick walks the last-seen RAM slot by slot (read, then check), then
// passes S_FLUSH; in_ready stays low until back in S_IDLE, longer on output stalls.
// Reset (rst, synchronous): all slots absent and not alive, time zero, scan
// countdown zero so the first tick scans; config at 3000 / 1000 ticks.
`default_nettype none

module heartbeat_failure_detector_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  kind,
  input  wire logic [hbfd_pkg::NODE_W-1:0] node,
  // failure result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [hbfd_pkg::NODE_W-1:0] failed_node,
  output logic                             last,
  // configuration write port
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [hbfd_pkg::CFG_W-1:0]  cfg_data
);

  hbfd_pkg::state_t                 state;
  logic [hbfd_pkg::THR_W-1:0]       failure_threshold;
  logic [hbfd_pkg::IVL_W-1:0]       scan_interval;
  logic [hbfd_pkg::TIME_W-1:0]      now_ticks;
  logic [hbfd_pkg::IVL_W-1:0]       scan_countdown;
  logic [hbfd_pkg::NODES-1:0]       entry_present;
  logic [hbfd_pkg::NODES-1:0]       entry_alive;
  logic [hbfd_pkg::NODE_W-1:0]      scan_idx;
  logic [hbfd_pkg::NODE_W-1:0]      pend_node;
  logic                             pend_valid;

  logic                             in_fire;
  logic                             node_ok;
  logic                             ram_we;
  logic                             ram_re;
  logic [hbfd_pkg::TIME_W-1:0]      ram_rdata;
  logic [hbfd_pkg::TIME_W-1:0]      age;
  logic                             slot_fail;
  logic                             out_free;
  logic                             stall;
  logic                             push;
  logic [hbfd_pkg::NODE_W-1:0]      push_node;
  logic                             push_last;
  logic [hbfd_pkg::IVL_W-1:0]       reload;
  logic                             scan_end;

  assign in_ready = (state == hbfd_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign node_ok  = (32'(node) < hbfd_pkg::NODES);

  // Last-seen time store
  assign ram_we = in_fire && node_ok &&
                  ((kind == hbfd_pkg::KIND_REGISTER) ||
                   ((kind == hbfd_pkg::KIND_HEARTBEAT) && entry_present[node]));
  assign ram_re = (state == hbfd_pkg::S_READ);

  hbfd_ram #(
    .DEPTH (hbfd_pkg::NODES),
    .WIDTH (hbfd_pkg::TIME_W),
    .AW    (hbfd_pkg::NODE_W)
  ) u_last_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node),
    .wdata (now_ticks),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Age check on the slot under scan
  assign age       = now_ticks - ram_rdata;
  assign slot_fail = entry_present[scan_idx] && entry_alive[scan_idx] &&
                     (age > {1'b0, failure_threshold});
  assign out_free  = !out_valid || out_ready;
  assign scan_end  = (scan_idx == hbfd_pkg::NODE_W'(hbfd_pkg::NODES - 1));

  // A failure is held back one step so the final one can carry the last flag
  always_comb begin
    push      = 1'b0;
    push_node = pend_node;
    push_last = 1'b0;
    stall     = 1'b0;
    case (state)
      hbfd_pkg::S_CHECK: begin
        if (slot_fail && pend_valid) begin
          if (out_free) begin
            push = 1'b1;
          end else begin
            stall = 1'b1;
          end
        end
      end
      hbfd_pkg::S_FLUSH: begin
        if (pend_valid && out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign reload = (scan_interval == '0) ? '0 : scan_interval - 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      failure_threshold <= hbfd_pkg::THRESHOLD_RESET;
      scan_interval     <= hbfd_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        hbfd_pkg::CFG_THRESHOLD: failure_threshold <= cfg_data;
        hbfd_pkg::CFG_INTERVAL:  scan_interval <= cfg_data[hbfd_pkg::IVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller: request handling and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= hbfd_pkg::S_IDLE;
      now_ticks      <= '0;
      scan_countdown <= '0;
      entry_present  <= '0;
      entry_alive    <= '0;
      scan_idx       <= '0;
      pend_valid     <= 1'b0;
    end else begin
      case (state)
        hbfd_pkg::S_IDLE: begin
          if (in_fire) begin
            if (kind == hbfd_pkg::KIND_TICK) begin
              now_ticks <= now_ticks + 1'b1;
              if (scan_countdown == '0) begin
                scan_countdown <= reload;
                scan_idx       <= '0;
                pend_valid     <= 1'b0;
                state          <= hbfd_pkg::S_READ;
              end else begin
                scan_countdown <= scan_countdown - 1'b1;
              end
            end else if (node_ok) begin
              case (kind)
                hbfd_pkg::KIND_REGISTER: begin
                  entry_present[node] <= 1'b1;
                  entry_alive[node]   <= 1'b1;
                end
                hbfd_pkg::KIND_REMOVE: begin
                  entry_present[node] <= 1'b0;
                  entry_alive[node]   <= 1'b0;
                end
                hbfd_pkg::KIND_HEARTBEAT: begin
                  if (entry_present[node]) begin
                    entry_alive[node] <= 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        hbfd_pkg::S_READ: begin
          state <= hbfd_pkg::S_CHECK;
        end
        hbfd_pkg::S_CHECK: begin
          if (!stall) begin
            if (slot_fail) begin
              entry_alive[scan_idx] <= 1'b0;
              pend_node             <= scan_idx;
              pend_valid            <= 1'b1;
            end
            if (scan_end) begin
              state <= hbfd_pkg::S_FLUSH;
            end else begin
              scan_idx <= scan_idx + 1'b1;
              state    <= hbfd_pkg::S_READ;
            end
          end
        end
        hbfd_pkg::S_FLUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
            state      <= hbfd_pkg::S_IDLE;
          end
        end
        default: begin
          state <= hbfd_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      failed_node <= push_node;
      last        <= push_last;
    end
  end

endmodule

`default_nettype wire

[src/hbfd_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
`default_nettype none

module hbfd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
